FILE: src/wsfu_pkg.sv
// Package for the frame unmasker: length codes, header offsets and the
// result record passed from the parser to the top level. No dependencies.
package wsfu_pkg;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [3:0] KEY_START_SHORT = 4'd2;
    localparam logic [3:0] KEY_START_16    = 4'd4;
    localparam logic [3:0] KEY_START_64    = 4'd10;

    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_EXT16 = 2'd1,
        LEN_EXT64 = 2'd2
    } len_kind_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       last;
    } wsfu_res_t;

    function automatic logic [3:0] key_start(input len_kind_t kind);
        logic [3:0] ks;
        unique case (kind)
            LEN_EXT16: ks = KEY_START_16;
            LEN_EXT64: ks = KEY_START_64;
            default:   ks = KEY_START_SHORT;
        endcase
        return ks;
    endfunction

endpackage

FILE: src/wsfu_parser.sv
// Header parser and payload unmasker state for the frame unmasker.
// Depends on wsfu_pkg; advances one byte per cycle in which step is high.
module wsfu_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic                rx_end,
    output wsfu_pkg::wsfu_res_t res
);
    import wsfu_pkg::*;

    logic [3:0]  header_count_reg, header_count_next;
    len_kind_t   length_kind_reg, length_kind_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic        in_payload_reg, in_payload_next;
    logic [1:0]  key_phase_reg, key_phase_next;

    logic [3:0]  ks;
    logic [3:0]  key_offset;
    logic [1:0]  key_idx;
    logic [7:0]  key_byte;

    assign key_byte   = mask_key_reg[{key_phase_reg, 3'b000} +: 8];
    assign ks         = key_start(length_kind_reg);
    assign key_offset = header_count_reg - ks;
    assign key_idx    = key_offset[1:0];

    assign res.emit = in_payload_reg;
    assign res.data = rx_byte ^ key_byte;
    assign res.last = rx_end;

    always_comb begin
        header_count_next = header_count_reg;
        length_kind_next  = length_kind_reg;
        mask_key_next     = mask_key_reg;
        in_payload_next   = in_payload_reg;
        key_phase_next    = key_phase_reg;
        if (step) begin
            if (in_payload_reg) begin
                key_phase_next = key_phase_reg + 2'd1;
            end else if (header_count_reg == 4'd0) begin
                header_count_next = 4'd1;
            end else if (header_count_reg == 4'd1) begin
                if (rx_byte[6:0] == LEN_CODE_16) begin
                    length_kind_next = LEN_EXT16;
                end else if (rx_byte[6:0] == LEN_CODE_64) begin
                    length_kind_next = LEN_EXT64;
                end else begin
                    length_kind_next = LEN_SHORT;
                end
                header_count_next = 4'd2;
            end else begin
                if (header_count_reg >= ks) begin
                    mask_key_next[{key_idx, 3'b000} +: 8] = rx_byte;
                    if (key_idx == 2'd3) begin
                        in_payload_next = 1'b1;
                        key_phase_next  = 2'd0;
                    end
                end
                header_count_next = header_count_reg + 4'd1;
            end
            if (rx_end) begin
                header_count_next = 4'd0;
                length_kind_next  = LEN_SHORT;
                in_payload_next   = 1'b0;
                key_phase_next    = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg <= 4'd0;
            length_kind_reg  <= LEN_SHORT;
            mask_key_reg     <= 32'd0;
            in_payload_reg   <= 1'b0;
            key_phase_reg    <= 2'd0;
        end else begin
            header_count_reg <= header_count_next;
            length_kind_reg  <= length_kind_next;
            mask_key_reg     <= mask_key_next;
            in_payload_reg   <= in_payload_next;
            key_phase_reg    <= key_phase_next;
        end
    end

endmodule

FILE: src/websocket_frame_unmasker.sv
// Top level of the frame unmasker: input register, parser and output register.
// Depends on wsfu_pkg and wsfu_parser.
//
//   channel  direction  tdata          tlast        tuser
//   s_       in         rx_byte[7:0]   rx_end       none
//   m_       out        payload_byte   payload_end  none
//
// One beat per cycle while the output register is free; a beat is held
// in the input register and then, if payload, in the output register.
// Header beats produce no output beat and never wait on m_tready.
// A full output register stalls only a payload beat held in the input register.
// Reset clears the parser state, the masking key and both valid flags.
module websocket_frame_unmasker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic       m_tlast
);
    import wsfu_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;

    wsfu_res_t  res;
    logic       out_free;
    logic       advance;
    logic       s_accept;

    wsfu_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .rx_end  (in_end_reg),
        .res     (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res.emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && res.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (advance && res.emit) begin
            out_byte_reg <= res.data;
            out_end_reg  <= res.last;
        end
    end

endmodule
